FILE: hdl/vrc_pkg.sv
// ----------------------------------------------------------------------------
// vrc_pkg
// types and constants shared by the velocity ramp command pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package vrc_pkg;

	// pipeline shape
	localparam int ROOT_STEPS   = 32;
	localparam int FRONT_STAGES = 2;
	localparam int BACK_STAGES  = 3;
	localparam int NUM_STAGES   = FRONT_STAGES + ROOT_STEPS + BACK_STAGES;

	// configuration register indexes
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_UPPER = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_LOWER = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_VEL_UPPER   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_VEL_LOWER   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_TIME   = 3'd4;

	// configuration reset values
	localparam logic [30:0]        ACCEL_UPPER_RST = 31'd65536;
	localparam logic signed [31:0] ACCEL_LOWER_RST = -32'sd65536;
	localparam logic [30:0]        VEL_UPPER_RST   = 31'd65536;
	localparam logic signed [31:0] VEL_LOWER_RST   = -32'sd65536;
	localparam logic [16:0]        STEP_TIME_RST   = 17'd655;

	// distances at or below this raw value count as zero (0.01 in Q16.16)
	localparam logic [32:0] DEAD_BAND = 33'd655;

	// reciprocal of five, exact for any 32-bit dividend with a shift of 34
	localparam logic [31:0] RECIP5      = 32'hCCCC_CCCD;
	localparam int          RECIP5_SHIFT = 34;

	// saturation limits of the command, held at the internal width
	localparam logic signed [34:0] CMD_MAX = 35'sd2147483647;
	localparam logic signed [34:0] CMD_MIN = -35'sd2147483648;

	typedef struct packed {
		logic [30:0]        accel_upper;
		logic signed [31:0] accel_lower;
		logic [30:0]        vel_upper;
		logic signed [31:0] vel_lower;
		logic [16:0]        step_time;
	} vrc_cfg_t;

	// remainder and partial root carried down the square-root chain
	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] root;
	} vrc_root_t;

	// sign of the distance and velocity window, riding along with the root
	typedef struct packed {
		logic               dneg;
		logic signed [34:0] vmin;
		logic signed [34:0] vmax;
	} vrc_side_t;

endpackage

`default_nettype wire

FILE: hdl/vrc_front.sv
// ----------------------------------------------------------------------------
// vrc_front
// distance, dead band, radicand and acceleration window (two stages)
// ----------------------------------------------------------------------------
`default_nettype none

module vrc_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [1:0]                en,
	input  wire logic                      in_v,
	input  wire vrc_pkg::vrc_cfg_t         cfg,
	input  wire logic signed [31:0]        target_position,
	input  wire logic signed [31:0]        current_position,
	input  wire logic signed [31:0]        current_velocity,
	output logic [1:0]                     v,
	output vrc_pkg::vrc_root_t             root_out,
	output vrc_pkg::vrc_side_t             side_out
);
	import vrc_pkg::*;

	logic signed [32:0] delta;
	logic [32:0]        mag_raw;
	logic [32:0]        mag_db;
	logic               lo_neg;
	logic [31:0]        lo_mag;
	logic [48:0]        lo_prod;
	logic [47:0]        hi_prod;

	logic               v_s1;
	logic [32:0]        mag_s1;
	logic               dneg_s1;
	logic signed [31:0] vel_s1;
	logic               lo_neg_s1;
	logic [32:0]        lo_step_s1;
	logic [31:0]        hi_step_s1;

	logic               v_s2;
	logic [63:0]        prod;
	logic signed [34:0] lo_sgn;
	logic signed [34:0] vel_ext;
	logic signed [34:0] vl_ext;
	logic signed [34:0] vu_ext;
	logic signed [34:0] vmin_raw;
	logic signed [34:0] vmax_raw;
	logic signed [34:0] vmin;
	logic signed [34:0] vmax;
	logic [63:0]        n_s2;
	vrc_side_t          side_s2;

	// distance to go with dead band
	always_comb begin
		delta   = $signed({target_position[31], target_position})
			- $signed({current_position[31], current_position});
		mag_raw = delta[32] ? 33'(-delta) : 33'(delta);
		mag_db  = (mag_raw <= DEAD_BAND) ? '0 : mag_raw;
	end

	// acceleration steps over one control period, magnitude truncated
	always_comb begin
		lo_neg  = cfg.accel_lower[31];
		lo_mag  = lo_neg ? (~cfg.accel_lower + 32'd1) : cfg.accel_lower;
		lo_prod = 49'(lo_mag) * 49'(cfg.step_time);
		hi_prod = 48'(cfg.accel_upper) * 48'(cfg.step_time);
	end

	// stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en[0]) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mag_s1     <= mag_db;
			dneg_s1    <= delta[32] && (mag_db != '0);
			vel_s1     <= current_velocity;
			lo_neg_s1  <= lo_neg;
			lo_step_s1 <= lo_prod[48:16];
			hi_step_s1 <= hi_prod[47:16];
		end
	end

	// radicand 2 * |dist| * accel_upper and velocity window
	always_comb begin
		prod     = 64'(mag_s1) * 64'(cfg.accel_upper);
		lo_sgn   = lo_neg_s1 ? -$signed({2'b00, lo_step_s1}) : $signed({2'b00, lo_step_s1});
		vel_ext  = $signed({{3{vel_s1[31]}}, vel_s1});
		vl_ext   = $signed({{3{cfg.vel_lower[31]}}, cfg.vel_lower});
		vu_ext   = $signed({4'b0000, cfg.vel_upper});
		vmin_raw = vel_ext + lo_sgn;
		vmax_raw = vel_ext + $signed({3'b000, hi_step_s1});
		vmin     = (vmin_raw < vl_ext) ? vl_ext : vmin_raw;
		vmax     = (vmax_raw > vu_ext) ? vu_ext : vmax_raw;
	end

	// stage two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en[1]) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			n_s2         <= {prod[62:0], 1'b0};
			side_s2.dneg <= dneg_s1;
			side_s2.vmin <= vmin;
			side_s2.vmax <= vmax;
		end
	end

	assign v        = {v_s2, v_s1};
	assign root_out = '{rem: n_s2, root: 64'd0};
	assign side_out = side_s2;

endmodule

`default_nettype wire

FILE: hdl/vrc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vrc_sqrt_cell
// one registered step of the digit-by-digit integer square root
// ----------------------------------------------------------------------------
`default_nettype none

module vrc_sqrt_cell #(
	parameter int STEP = 0
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_v,
	input  wire vrc_pkg::vrc_root_t root_in,
	input  wire vrc_pkg::vrc_side_t side_in,
	output logic                    out_v,
	output vrc_pkg::vrc_root_t      root_out,
	output vrc_pkg::vrc_side_t      side_out
);
	import vrc_pkg::*;

	// trial bit of this step, working down from 2^62 two places a cell
	localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

	logic [63:0] trial;
	vrc_root_t   nxt;
	logic        v_q;
	vrc_root_t   root_q;
	vrc_side_t   side_q;

	// compare and subtract
	always_comb begin
		trial = root_in.root + BIT;
		if (root_in.rem >= trial) begin
			nxt.rem  = root_in.rem - trial;
			nxt.root = (root_in.root >> 1) + BIT;
		end else begin
			nxt.rem  = root_in.rem;
			nxt.root = root_in.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_q <= nxt;
			side_q <= side_in;
		end
	end

	assign out_v    = v_q;
	assign root_out = root_q;
	assign side_out = side_q;

endmodule

`default_nettype wire

FILE: hdl/vrc_back.sv
// ----------------------------------------------------------------------------
// vrc_back
// scale root by 0.8, apply sign, clamp to window and saturate (three stages)
// ----------------------------------------------------------------------------
`default_nettype none

module vrc_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [2:0]         en,
	input  wire logic               in_v,
	input  wire vrc_pkg::vrc_root_t root_in,
	input  wire vrc_pkg::vrc_side_t side_in,
	output logic [2:0]              v,
	output logic signed [31:0]      cmd
);
	import vrc_pkg::*;

	logic               v_s1;
	logic [31:0]        root_s1;
	logic [63:0]        recip_s1;
	vrc_side_t          side_s1;

	logic [29:0]        q;
	logic [31:0]        five_q;
	logic [2:0]         rem;
	logic [1:0]         frac;
	logic               v_s2;
	logic [31:0]        mag_s2;
	vrc_side_t          side_s2;

	logic signed [34:0] brake;
	logic signed [34:0] lo_clamp;
	logic signed [34:0] win;
	logic signed [31:0] sat;
	logic               v_s3;
	logic signed [31:0] cmd_s3;

	// stage one: multiply by reciprocal of five
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en[0]) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			root_s1  <= root_in.root[31:0];
			recip_s1 <= 64'(root_in.root[31:0]) * 64'(RECIP5);
			side_s1  <= side_in;
		end
	end

	// floor(4r/5) = 4q + (rem > 0 ? rem - 1 : 0) with r = 5q + rem
	always_comb begin
		q      = recip_s1[63:RECIP5_SHIFT];
		five_q = {q, 2'b00} + {2'b00, q};
		rem    = root_s1[2:0] - five_q[2:0];
		frac   = (rem == 3'd0) ? 2'd0 : 2'(rem - 3'd1);
	end

	// stage two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en[1]) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			mag_s2  <= {q, 2'b00} + {30'd0, frac};
			side_s2 <= side_s1;
		end
	end

	// sign, clamp into window (upper bound wins) and saturate
	always_comb begin
		brake    = side_s2.dneg ? -$signed({3'b000, mag_s2}) : $signed({3'b000, mag_s2});
		lo_clamp = (brake < side_s2.vmin) ? side_s2.vmin : brake;
		win      = (lo_clamp > side_s2.vmax) ? side_s2.vmax : lo_clamp;
		if (win > CMD_MAX) begin
			sat = CMD_MAX[31:0];
		end else if (win < CMD_MIN) begin
			sat = CMD_MIN[31:0];
		end else begin
			sat = win[31:0];
		end
	end

	// stage three: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en[2]) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			cmd_s3 <= sat;
		end
	end

	assign v   = {v_s3, v_s2, v_s1};
	assign cmd = cmd_s3;

endmodule

`default_nettype wire

FILE: hdl/velocity_ramp_command.sv
// ----------------------------------------------------------------------------
// velocity_ramp_command
// trapezoidal velocity profile command for one joint per transaction
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake               payload
//  item      in   item_valid/item_stall   target_position, current_position,
//                                         current_velocity
//  cmd       out  cmd_valid/cmd_stall     velocity_command
//  cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// one transaction per cycle while no stall has filled the stages; each result
// passes 2 front stages, a chain of 32 square-root cells and 3 back stages.
// reset clears all stage valid bits and loads the default register values.
// a stalled result holds only the unbroken run of full stages behind it, so
// input is taken while a result waits as long as some stage is empty.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module velocity_ramp_command (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire logic signed [31:0]               target_position,
	input  wire logic signed [31:0]               current_position,
	input  wire logic signed [31:0]               current_velocity,
	output logic                                  cmd_valid,
	input  wire logic                             cmd_stall,
	output logic signed [31:0]                    velocity_command,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [vrc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [31:0]                      cfg_data
);
	import vrc_pkg::*;

	localparam int LAST = NUM_STAGES - 1;

	vrc_cfg_t          cfg_q;
	logic [LAST:0]     v;
	logic [LAST:0]     en;
	logic              en_out;
	vrc_root_t         root_c [0:ROOT_STEPS];
	vrc_side_t         side_c [0:ROOT_STEPS];

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_upper <= ACCEL_UPPER_RST;
			cfg_q.accel_lower <= ACCEL_LOWER_RST;
			cfg_q.vel_upper   <= VEL_UPPER_RST;
			cfg_q.vel_lower   <= VEL_LOWER_RST;
			cfg_q.step_time   <= STEP_TIME_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ACCEL_UPPER: cfg_q.accel_upper <= cfg_data[30:0];
				REG_ACCEL_LOWER: cfg_q.accel_lower <= cfg_data;
				REG_VEL_UPPER:   cfg_q.vel_upper   <= cfg_data[30:0];
				REG_VEL_LOWER:   cfg_q.vel_lower   <= cfg_data;
				REG_STEP_TIME:   cfg_q.step_time   <= cfg_data[16:0];
				default: begin
				end
			endcase
		end
	end

	// a stage moves when it or any stage ahead of it is empty, or the output is taken
	assign en_out = !v[LAST] || !cmd_stall;

	for (genvar k = 0; k <= LAST; k++) begin : g_en
		assign en[k] = en_out || !(&v[LAST:k]);
	end

	assign item_stall = !en[0];

	// distance, radicand and window
	vrc_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (en[FRONT_STAGES-1:0]),
		.in_v             (item_valid),
		.cfg              (cfg_q),
		.target_position  (target_position),
		.current_position (current_position),
		.current_velocity (current_velocity),
		.v                (v[FRONT_STAGES-1:0]),
		.root_out         (root_c[0]),
		.side_out         (side_c[0])
	);

	// square-root chain
	for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_cell
		vrc_sqrt_cell #(
			.STEP (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en[FRONT_STAGES+i]),
			.in_v     (v[FRONT_STAGES+i-1]),
			.root_in  (root_c[i]),
			.side_in  (side_c[i]),
			.out_v    (v[FRONT_STAGES+i]),
			.root_out (root_c[i+1]),
			.side_out (side_c[i+1])
		);
	end

	// scaling, clamp and result register
	vrc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en[LAST:LAST-BACK_STAGES+1]),
		.in_v    (v[LAST-BACK_STAGES]),
		.root_in (root_c[ROOT_STEPS]),
		.side_in (side_c[ROOT_STEPS]),
		.v       (v[LAST:LAST-BACK_STAGES+1]),
		.cmd     (velocity_command)
	);

	assign cmd_valid = v[LAST];

endmodule

`default_nettype wire

FILE: test/velocity_command_checker.sv
// ----------------------------------------------------------------------------
// velocity_command_checker
// watches the item, command and register channels of velocity_ramp_command,
// predicts each velocity command from the accepted joint sample and the
// current register values, and compares commands in order as they leave
// ----------------------------------------------------------------------------

module velocity_command_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	input  logic                                 item_stall,
	input  logic signed [31:0]                   target_position,
	input  logic signed [31:0]                   current_position,
	input  logic signed [31:0]                   current_velocity,
	input  logic                                 cmd_valid,
	input  logic                                 cmd_stall,
	input  logic signed [31:0]                   velocity_command,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [vrc_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [31:0]                          cfg_data,
	output int                                   fail_count,
	output int                                   pending,
	output int                                   checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import vrc_pkg::*;

	vrc_cfg_t           regs;
	logic signed [31:0] expected_commands[$];
	logic signed [31:0] want;

	// acceleration times control period, magnitude truncated, sign put back
	function automatic longint accel_over_period(input longint acc, input longint unsigned dt);
		longint unsigned mag;
		longint unsigned prod;
		mag = (acc < 0) ? longint'(-acc) : longint'(acc);
		prod = (mag * dt) >> 16;
		return (acc < 0) ? -longint'(prod) : longint'(prod);
	endfunction

	// braking velocity clamped to the reachable window and the limits
	function automatic logic signed [31:0] ramp_command(input vrc_cfg_t c,
		input logic signed [31:0] tgt, input logic signed [31:0] pos,
		input logic signed [31:0] vel);
		longint          delta;
		longint          brake;
		longint          vmin;
		longint          vmax;
		longint          cmd;
		longint unsigned span;
		longint unsigned radicand;
		longint unsigned root;
		longint unsigned trial;
		delta = longint'(tgt) - longint'(pos);
		span = (delta < 0) ? longint'(-delta) : longint'(delta);
		if (span <= DEAD_BAND)
			span = 0;
		radicand = 64'd2 * span * longint'(c.accel_upper);
		// integer square root, one result bit at a time from the top
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= radicand)
				root = trial;
		end
		root = (root * 4) / 5;
		brake = (delta < 0 && span != 0) ? -longint'(root) : longint'(root);
		vmin = longint'(vel) + accel_over_period(longint'(c.accel_lower), c.step_time);
		if (vmin < longint'(c.vel_lower))
			vmin = longint'(c.vel_lower);
		vmax = longint'(vel) + accel_over_period(longint'(c.accel_upper), c.step_time);
		if (vmax > longint'(c.vel_upper))
			vmax = longint'(c.vel_upper);
		// upper bound wins when the window is empty
		cmd = (brake < vmin) ? vmin : brake;
		if (cmd > vmax)
			cmd = vmax;
		if (cmd > longint'(CMD_MAX))
			cmd = longint'(CMD_MAX);
		if (cmd < longint'(CMD_MIN))
			cmd = longint'(CMD_MIN);
		return cmd[31:0];
	endfunction

	// prediction, comparison and register shadow
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.accel_upper = ACCEL_UPPER_RST;
			regs.accel_lower = ACCEL_LOWER_RST;
			regs.vel_upper   = VEL_UPPER_RST;
			regs.vel_lower   = VEL_LOWER_RST;
			regs.step_time   = STEP_TIME_RST;
			expected_commands.delete();
			fail_count = 0;
			pending    = 0;
			checked    = 0;
		end else begin
			// command transaction against the oldest prediction
			if (cmd_valid && !cmd_stall) begin
				if (expected_commands.size() == 0) begin
					fail_count++;
					$display("%0t: command with none expected, expected none, actual %0d",
						$time, velocity_command);
				end else begin
					want = expected_commands.pop_front();
					checked++;
					if (velocity_command !== want) begin
						fail_count++;
						$display("%0t: velocity_command mismatch, expected %0d, actual %0d",
							$time, want, velocity_command);
					end
				end
			end
			// joint sample transaction
			if (item_valid && !item_stall)
				expected_commands.push_back(ramp_command(regs, target_position,
					current_position, current_velocity));
			// register write transaction, unknown indexes ignored
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ACCEL_UPPER: regs.accel_upper = cfg_data[30:0];
					REG_ACCEL_LOWER: regs.accel_lower = cfg_data;
					REG_VEL_UPPER:   regs.vel_upper   = cfg_data[30:0];
					REG_VEL_LOWER:   regs.vel_lower   = cfg_data;
					REG_STEP_TIME:   regs.step_time   = cfg_data[16:0];
					default: ;
				endcase
			end
			pending = expected_commands.size();
		end
	end

endmodule

FILE: test/tb_velocity_ramp_command.sv
// ----------------------------------------------------------------------------
// tb_velocity_ramp_command
// drives joint samples and register settings into velocity_ramp_command with
// random gaps and back-pressure; the checker beside the block predicts and
// compares every velocity command, this module only gives the verdict
// ----------------------------------------------------------------------------

module tb_velocity_ramp_command;
	timeunit 1ns;
	timeprecision 1ps;
	import vrc_pkg::*;

	localparam int SAMPLES_PER_SETTING = 127;
	localparam int SETTLE_CYCLES       = NUM_STAGES + 8;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_stall;
	logic signed [31:0]     target_position = '0;
	logic signed [31:0]     current_position = '0;
	logic signed [31:0]     current_velocity = '0;
	logic                   cmd_valid;
	logic                   cmd_stall = 1'b0;
	logic signed [31:0]     velocity_command;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [31:0]            cfg_data = '0;

	int fail_count;
	int pending;
	int checked;
	int send_idle = 0;
	int stall_pct = 0;
	int samples_sent = 0;
	int settings_used = 0;

	always #1 clk = ~clk;

	velocity_ramp_command uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.target_position  (target_position),
		.current_position (current_position),
		.current_velocity (current_velocity),
		.cmd_valid        (cmd_valid),
		.cmd_stall        (cmd_stall),
		.velocity_command (velocity_command),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	velocity_command_checker cmd_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.target_position  (target_position),
		.current_position (current_position),
		.current_velocity (current_velocity),
		.cmd_valid        (cmd_valid),
		.cmd_stall        (cmd_stall),
		.velocity_command (velocity_command),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.fail_count       (fail_count),
		.pending          (pending),
		.checked          (checked)
	);

	// command side back-pressure
	always @(posedge clk) begin
		cmd_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	// random value of either sign up to lim in magnitude
	function automatic int spread(input int unsigned lim);
		int mag;
		mag = int'($urandom_range(lim));
		return $urandom_range(1) ? -mag : mag;
	endfunction

	// one joint sample, held until taken
	task automatic send_sample(input logic signed [31:0] tgt, input logic signed [31:0] pos,
		input logic signed [31:0] vel);
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid       <= 1'b1;
		target_position  <= tgt;
		current_position <= pos;
		current_velocity <= vel;
		do @(posedge clk); while (item_stall);
		samples_sent++;
	endtask

	// one register write transaction, valid left high for the next one
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// full register set plus a write to an unused index
	task automatic apply_settings(input logic [31:0] au, input logic [31:0] al,
		input logic [31:0] vu, input logic [31:0] vl, input logic [31:0] dt);
		logic [CFG_INDEX_W-1:0] spare;
		spare = CFG_INDEX_W'($urandom_range(int'(REG_STEP_TIME) + 1, (1 << CFG_INDEX_W) - 1));
		write_reg(REG_ACCEL_UPPER, au);
		write_reg(REG_ACCEL_LOWER, al);
		write_reg(REG_VEL_UPPER, vu);
		write_reg(REG_VEL_LOWER, vl);
		write_reg(REG_STEP_TIME, dt);
		write_reg(spare, $urandom);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// stop sending and wait for every command to come back
	task automatic drain_pipeline();
		item_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_settings(input int kind);
		case (kind)
			0: apply_settings($urandom_range(1, 20 << 16), -int'($urandom_range(1, 20 << 16)),
				$urandom_range(0, 8 << 16), -int'($urandom_range(0, 8 << 16)),
				$urandom_range(1, 65536));
			1: apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
				32'h0001_0000);
			2: apply_settings($urandom, $urandom, $urandom, $urandom, $urandom);
			default: apply_settings(32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1);
		endcase
	endtask

	// mostly plausible joint states, some raw noise
	task automatic random_sample();
		logic signed [31:0] pos;
		logic signed [31:0] delta;
		logic signed [31:0] vel;
		if ($urandom_range(9) < 3) begin
			send_sample($urandom, $urandom, $urandom);
		end else begin
			pos = spread(1 << 26);
			case ($urandom_range(3))
				0: delta = spread(1400);
				1: delta = spread(1 << 18);
				2: delta = spread(1 << 24);
				default: delta = $urandom;
			endcase
			vel = $urandom_range(1) ? spread(1 << 20) : spread(1 << 23);
			send_sample(pos + delta, pos, vel);
		end
	endtask

	// stimulus and verdict
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: dead band edges, extreme distances, empty windows
		send_sample(32'sd0, 32'sd0, 32'sd0);
		send_sample(32'sd655, 32'sd0, 32'sd0);
		send_sample(32'sd656, 32'sd0, 32'sd0);
		send_sample(32'sd0, 32'sd655, 32'sd0);
		send_sample(32'sd0, 32'sd656, 32'sd0);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'sd0);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'sd0);
		send_sample(32'sd0, 32'sd0, 32'h7FFF_FFFF);
		send_sample(32'sd0, 32'sd0, 32'h8000_0000);
		send_sample(32'sd100, 32'sd0, 32'sd60000);
		drain_pipeline();

		// widest limits
		apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_sample(32'sd0, 32'sd0, 32'h7FFF_FFFF);
		send_sample(32'sd0, 32'sd0, 32'h8000_0000);
		send_sample(32'sd1 << 20, 32'sd0, 32'sd0);
		drain_pipeline();

		// zero braking gain, positive lower limits, longest period
		apply_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_FFFF);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'sd0);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_sample(32'sd0, 32'sd0, 32'sd0);
		send_sample(32'sd1 << 16, 32'sd0, 32'h7FFF_FFFF);
		drain_pipeline();

		// tightest limits and a zero period
		apply_settings(32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFE_0000);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'sd0);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'sd5);
		send_sample(32'sd0, 32'sd0, 32'sd0);

		// random part under three idling mixes
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle = 27;
					stall_pct = 60;
				end
				1: begin
					send_idle = 60;
					stall_pct = 27;
				end
				default: begin
					send_idle = 0;
					stall_pct = 0;
				end
			endcase
			for (int s = 0; s < 4; s++) begin
				drain_pipeline();
				random_settings(s);
				repeat (SAMPLES_PER_SETTING) random_sample();
			end
		end
		drain_pipeline();

		$display("checked %0d velocity commands from %0d joint samples over %0d register settings",
			checked, samples_sent, settings_used);
		$display("idling mixes sender/receiver: 27/60, 60/27 and none, with extreme limits");
		if (fail_count == 0)
			$display("** velocity_ramp_command: PASSED **");
		else
			$display("** velocity_ramp_command: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("** velocity_ramp_command: FAILED **");
		$finish;
	end

endmodule

FILE: sim.f
hdl/vrc_pkg.sv
hdl/vrc_front.sv
hdl/vrc_sqrt_cell.sv
hdl/vrc_back.sv
hdl/velocity_ramp_command.sv
test/velocity_command_checker.sv
test/tb_velocity_ramp_command.sv
